// ----- sv/mi3_pkg.sv -----
// shared constants, types and helpers for the 3x3 matrix inverse pipeline
package mi3_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EW = 32;
	localparam int EPSW = 17;
	localparam logic [EPSW-1:0] EPS_RST = 17'd1;
	localparam int ADJW = 2 * EW + 1;
	localparam int MAGW = 2 * EW;
	localparam int DETW = 3 * EW + 1;
	localparam int DMAGW = 3 * EW;
	localparam int QB = EW + 1;
	localparam int NEL = 9;

	localparam int ADJ_ST = 2;
	localparam int DET_ST = 4;
	localparam int DIV_ST = QB + 2;
	localparam int NS = ADJ_ST + DET_ST + DIV_ST;

	// cofactor operand indexes: adj = a[0]*a[1] - a[2]*a[3]
	localparam int ADJ_IDX [NEL][4] = '{
		'{4, 8, 5, 7},
		'{2, 7, 1, 8},
		'{1, 5, 2, 4},
		'{5, 6, 3, 8},
		'{0, 8, 2, 6},
		'{2, 3, 0, 5},
		'{3, 7, 4, 6},
		'{1, 6, 0, 7},
		'{0, 4, 1, 3}
	};

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [ADJW-1:0] adj_t;

	function automatic int rem_w(input int frac);
		int a;
		int b;
		a = MAGW + 2 * frac + 1;
		b = DMAGW + QB;
		return ((a > b) ? a : b) + 1;
	endfunction

	function automatic elem_t sat32(input logic neg, input logic big,
			input logic [QB-1:0] mag);
		elem_t r;
		if (!neg) begin
			if (big || mag > {2'b00, {(EW-1){1'b1}}})
				r = {1'b0, {(EW-1){1'b1}}};
			else
				r = elem_t'(mag[EW-1:0]);
		end else begin
			if (big || mag > {2'b01, {(EW-1){1'b0}}})
				r = {1'b1, {(EW-1){1'b0}}};
			else
				r = elem_t'({EW{1'b0}} - mag[EW-1:0]);
		end
		return r;
	endfunction

endpackage

// ----- sv/mi3_adj.sv -----
// cofactor products and adjugate, two pipeline stages
module mi3_adj (
	input  logic                               clk,
	input  logic [mi3_pkg::ADJ_ST-1:0]         en,
	input  mi3_pkg::elem_t                     a [mi3_pkg::NEL],
	output mi3_pkg::adj_t                      adj [mi3_pkg::NEL],
	output mi3_pkg::elem_t                     row0 [3]
);
	localparam int NEL = mi3_pkg::NEL;
	localparam int MAGW = mi3_pkg::MAGW;
	localparam int ADJW = mi3_pkg::ADJW;

	logic signed [MAGW-1:0] pp_s1 [NEL];
	logic signed [MAGW-1:0] pn_s1 [NEL];
	mi3_pkg::elem_t         row0_s1 [3];
	mi3_pkg::adj_t          adj_s2 [NEL];
	mi3_pkg::elem_t         row0_s2 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NEL; i++) begin
				pp_s1[i] <= a[mi3_pkg::ADJ_IDX[i][0]] * a[mi3_pkg::ADJ_IDX[i][1]];
				pn_s1[i] <= a[mi3_pkg::ADJ_IDX[i][2]] * a[mi3_pkg::ADJ_IDX[i][3]];
			end
			for (int j = 0; j < 3; j++)
				row0_s1[j] <= a[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < NEL; i++)
				adj_s2[i] <= ADJW'(pp_s1[i]) - ADJW'(pn_s1[i]);
			row0_s2 <= row0_s1;
		end
	end

	assign adj = adj_s2;
	assign row0 = row0_s2;

endmodule

// ----- sv/mi3_det.sv -----
// determinant, singular test and division operands, four pipeline stages
module mi3_det #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic [mi3_pkg::DET_ST-1:0]         en,
	input  mi3_pkg::adj_t                      adj [mi3_pkg::NEL],
	input  mi3_pkg::elem_t                     row0 [3],
	input  logic [mi3_pkg::EPSW-1:0]           eps,
	output logic [mi3_pkg::rem_w(FRAC_BITS)-1:0] num [mi3_pkg::NEL],
	output logic                               neg [mi3_pkg::NEL],
	output logic [mi3_pkg::DMAGW-1:0]          dmag,
	output logic                               sing,
	output mi3_pkg::elem_t                     sres [mi3_pkg::NEL]
);
	localparam int NEL = mi3_pkg::NEL;
	localparam int EW = mi3_pkg::EW;
	localparam int MAGW = mi3_pkg::MAGW;
	localparam int ADJW = mi3_pkg::ADJW;
	localparam int DETW = mi3_pkg::DETW;
	localparam int DMAGW = mi3_pkg::DMAGW;
	localparam int QB = mi3_pkg::QB;
	localparam int RW = mi3_pkg::rem_w(FRAC_BITS);

	logic [ADJW-1:0] am_c [3];
	logic [EW-1:0]   xm_c [3];

	logic [2*EW-1:0]        plo_s3 [3];
	logic [2*EW-1:0]        phi_s3 [3];
	logic                   tneg_s3 [3];
	mi3_pkg::adj_t          adj_s3 [NEL];
	logic signed [DETW-1:0] term_s4 [3];
	mi3_pkg::adj_t          adj_s4 [NEL];
	logic signed [DETW-1:0] det_s5;
	mi3_pkg::adj_t          adj_s5 [NEL];

	logic             detneg_c;
	logic [DETW-1:0]  dabs_c;
	logic [DMAGW-1:0] dmag_c;
	logic [DMAGW-1:0] thr_c;
	logic [ADJW-1:0]  m_c [NEL];
	logic [ADJW-1:0]  ms_c [NEL];

	logic [RW-1:0]    num_s6 [NEL];
	logic             neg_s6 [NEL];
	logic [DMAGW-1:0] dmag_s6;
	logic             sing_s6;
	mi3_pkg::elem_t   sres_s6 [NEL];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			am_c[j] = adj[3*j][ADJW-1] ? ADJW'(0) - adj[3*j] : adj[3*j];
			xm_c[j] = row0[j][EW-1] ? EW'(0) - row0[j] : row0[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= am_c[j][EW-1:0] * xm_c[j];
				phi_s3[j] <= am_c[j][MAGW-1:EW] * xm_c[j];
				tneg_s3[j] <= adj[3*j][ADJW-1] ^ row0[j][EW-1];
			end
			adj_s3 <= adj;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < 3; j++) begin
				if (tneg_s3[j])
					term_s4[j] <= DETW'(0) - ((DETW'(phi_s3[j]) << EW) + DETW'(plo_s3[j]));
				else
					term_s4[j] <= (DETW'(phi_s3[j]) << EW) + DETW'(plo_s3[j]);
			end
			adj_s4 <= adj_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			adj_s5 <= adj_s4;
		end
	end

	always_comb begin
		detneg_c = det_s5[DETW-1];
		dabs_c = detneg_c ? DETW'(0) - det_s5 : det_s5;
		dmag_c = dabs_c[DMAGW-1:0];
		thr_c = DMAGW'(eps) << (2 * FRAC_BITS);
		for (int i = 0; i < NEL; i++) begin
			m_c[i] = adj_s5[i][ADJW-1] ? ADJW'(0) - adj_s5[i] : adj_s5[i];
			ms_c[i] = (m_c[i] + (ADJW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < NEL; i++) begin
				num_s6[i] <= (RW'(m_c[i][MAGW-1:0]) << (2 * FRAC_BITS))
					+ RW'(dmag_c >> 1);
				neg_s6[i] <= adj_s5[i][ADJW-1] ^ detneg_c;
				sres_s6[i] <= mi3_pkg::sat32(adj_s5[i][ADJW-1],
					|ms_c[i][ADJW-1:QB], ms_c[i][QB-1:0]);
			end
			dmag_s6 <= dmag_c;
			sing_s6 <= (dmag_c <= thr_c);
		end
	end

	assign num = num_s6;
	assign neg = neg_s6;
	assign dmag = dmag_s6;
	assign sing = sing_s6;
	assign sres = sres_s6;

endmodule

// ----- sv/mi3_div.sv -----
// restoring divider, one quotient bit per stage, then saturation and output select
module mi3_div #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic [mi3_pkg::DIV_ST-1:0]         en,
	input  logic [mi3_pkg::rem_w(FRAC_BITS)-1:0] num [mi3_pkg::NEL],
	input  logic                               neg [mi3_pkg::NEL],
	input  logic [mi3_pkg::DMAGW-1:0]          dmag,
	input  logic                               sing,
	input  mi3_pkg::elem_t                     sres [mi3_pkg::NEL],
	output mi3_pkg::elem_t                     inv [mi3_pkg::NEL],
	output logic                               singular
);
	localparam int NEL = mi3_pkg::NEL;
	localparam int DMAGW = mi3_pkg::DMAGW;
	localparam int QB = mi3_pkg::QB;
	localparam int RW = mi3_pkg::rem_w(FRAC_BITS);

	logic [RW-1:0]    rem_s [QB+1][NEL];
	logic [QB-1:0]    quo_s [QB+1][NEL];
	logic             ov_s [QB+1][NEL];
	logic             neg_s [QB+1][NEL];
	mi3_pkg::elem_t   sres_s [QB+1][NEL];
	logic [DMAGW-1:0] dmag_s [QB+1];
	logic             sing_s [QB+1];

	mi3_pkg::elem_t   inv_so [NEL];
	logic             sing_so;

	// overflow check: quotient would not fit in the quotient bits
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NEL; i++) begin
				rem_s[0][i] <= num[i];
				quo_s[0][i] <= '0;
				ov_s[0][i] <= num[i] >= (RW'(dmag) << QB);
				neg_s[0][i] <= neg[i];
				sres_s[0][i] <= sres[i];
			end
			dmag_s[0] <= dmag;
			sing_s[0] <= sing;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_bit
		localparam int K = QB - j;
		always_ff @(posedge clk) begin
			if (en[j]) begin
				for (int i = 0; i < NEL; i++) begin
					if (rem_s[j-1][i] >= (RW'(dmag_s[j-1]) << K)) begin
						rem_s[j][i] <= rem_s[j-1][i] - (RW'(dmag_s[j-1]) << K);
						quo_s[j][i] <= quo_s[j-1][i] | (QB'(1) << K);
					end else begin
						rem_s[j][i] <= rem_s[j-1][i];
						quo_s[j][i] <= quo_s[j-1][i];
					end
					ov_s[j][i] <= ov_s[j-1][i];
					neg_s[j][i] <= neg_s[j-1][i];
					sres_s[j][i] <= sres_s[j-1][i];
				end
				dmag_s[j] <= dmag_s[j-1];
				sing_s[j] <= sing_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[QB+1]) begin
			for (int i = 0; i < NEL; i++) begin
				if (sing_s[QB])
					inv_so[i] <= sres_s[QB][i];
				else
					inv_so[i] <= mi3_pkg::sat32(neg_s[QB][i], ov_s[QB][i], quo_s[QB][i]);
			end
			sing_so <= sing_s[QB];
		end
	end

	assign inv = inv_so;
	assign singular = sing_so;

endmodule

// ----- sv/matrix3_inverse.sv -----
// top level of the 3x3 fixed-point matrix inverse pipeline
//
// in channel: one matrix a00..a22 per item, signed fixed point with
// FRAC_BITS fraction bits, taken when in_valid is high and in_stall low
// out channel: inv00..inv22 and singular, taken when out_valid is high
// and out_stall low; singular marks an unscaled, rounded adjugate
// config: cfg_data is written to det_epsilon when cfg_valid and cfg_ready
// are high; cfg_ready is always high, write only while the pipeline is empty
// throughput: one item per cycle while out_stall is low, set by the 41-stage pipeline in which
// the divider resolves one quotient bit of all nine elements per stage
// stall: a stalled stage holds its item; empty stages ahead still fill,
// so in_stall rises only when every stage holds an item
// reset: arst_n clears all stage valid bits and sets det_epsilon to 1
module matrix3_inverse #(
	parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [31:0]       a00,
	input  logic signed [31:0]       a01,
	input  logic signed [31:0]       a02,
	input  logic signed [31:0]       a10,
	input  logic signed [31:0]       a11,
	input  logic signed [31:0]       a12,
	input  logic signed [31:0]       a20,
	input  logic signed [31:0]       a21,
	input  logic signed [31:0]       a22,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [31:0]       inv00,
	output logic signed [31:0]       inv01,
	output logic signed [31:0]       inv02,
	output logic signed [31:0]       inv10,
	output logic signed [31:0]       inv11,
	output logic signed [31:0]       inv12,
	output logic signed [31:0]       inv20,
	output logic signed [31:0]       inv21,
	output logic signed [31:0]       inv22,
	output logic                     singular,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [16:0]              cfg_data
);
	localparam int NS = mi3_pkg::NS;
	localparam int NEL = mi3_pkg::NEL;
	localparam int ADJ_ST = mi3_pkg::ADJ_ST;
	localparam int DET_ST = mi3_pkg::DET_ST;
	localparam int RW = mi3_pkg::rem_w(FRAC_BITS);

	logic [mi3_pkg::EPSW-1:0] eps_q;
	logic [NS-1:0]            v_q;
	logic [NS-1:0]            en;

	mi3_pkg::elem_t           a_w [NEL];
	mi3_pkg::adj_t            adj_w [NEL];
	mi3_pkg::elem_t           row0_w [3];
	logic [RW-1:0]            num_w [NEL];
	logic                     neg_w [NEL];
	logic [mi3_pkg::DMAGW-1:0] dmag_w;
	logic                     sing_w;
	mi3_pkg::elem_t           sres_w [NEL];
	mi3_pkg::elem_t           inv_w [NEL];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= mi3_pkg::EPS_RST;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= cfg_data;
		end
	end

	always_comb begin
		en[NS-1] = !v_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= in_valid;
			for (int k = 1; k < NS; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	assign in_stall = !en[0];
	assign out_valid = v_q[NS-1];

	assign a_w = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

	mi3_adj u_adj (
		.clk  (clk),
		.en   (en[ADJ_ST-1:0]),
		.a    (a_w),
		.adj  (adj_w),
		.row0 (row0_w)
	);

	mi3_det #(
		.FRAC_BITS (FRAC_BITS)
	) u_det (
		.clk  (clk),
		.en   (en[ADJ_ST+DET_ST-1:ADJ_ST]),
		.adj  (adj_w),
		.row0 (row0_w),
		.eps  (eps_q),
		.num  (num_w),
		.neg  (neg_w),
		.dmag (dmag_w),
		.sing (sing_w),
		.sres (sres_w)
	);

	mi3_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.en       (en[NS-1:ADJ_ST+DET_ST]),
		.num      (num_w),
		.neg      (neg_w),
		.dmag     (dmag_w),
		.sing     (sing_w),
		.sres     (sres_w),
		.inv      (inv_w),
		.singular (singular)
	);

	assign inv00 = inv_w[0];
	assign inv01 = inv_w[1];
	assign inv02 = inv_w[2];
	assign inv10 = inv_w[3];
	assign inv11 = inv_w[4];
	assign inv12 = inv_w[5];
	assign inv20 = inv_w[6];
	assign inv21 = inv_w[7];
	assign inv22 = inv_w[8];

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_q[0])
		else $error("accepted item did not enter the first stage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_q[0])
		else $error("input stalled while the first stage is empty");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !v_q[NS-2] |=> !out_valid)
		else $error("output item repeated after it was taken");

endmodule
